>>> hw/rtl/sle_pkg.sv
// Shared constants, codes and types of the sequential list engine.
package sle_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int CAP_W      = 9;
  localparam int POS_W      = 9;
  localparam int CMP_W      = (LEN_W > CAP_W) ? LEN_W : CAP_W;
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 2;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

endpackage

>>> hw/rtl/sequential_list_engine.sv
// Top level of the sequential list engine: capacity register, sequencer and list memory.
//
// A request is taken when start is high and busy is low, and exactly one result is
// shown on the out_ ports for one cycle with out_strobe high; the receiver cannot
// stall it, so it must capture the result in that cycle. Range and full errors, clear
// and unused actions give their result in the cycle after start without raising busy.
// Get captures the entry in S_GET_CAP. Insert shifts entries up in S_INS_SHIFT and
// writes the value in S_INS_PUT; delete shifts later entries down in S_DEL_SHIFT; find
// reads from position 0 in S_FIND until a match or the end. The single read and single
// write port of the list memory set the pace: the walk moves one entry per cycle.
// The capacity register may be written only while the block is idle.
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_data,
  output logic                    out_strobe,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [IDX_W-1:0]        out_found_index,
  output logic [CNT_W-1:0]        out_count
);

  logic [CAP_W-1:0]      cap_r;
  logic [CMP_W-1:0]      eff_cap;
  ram_req_t              ram_req;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  assign eff_cap = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);

  sle_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_value        (in_value),
    .eff_cap         (eff_cap),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  sle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hw/rtl/sle_ram.sv
// Generic single-write, single-read memory with a registered read port.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/sle_ctrl.sv
// Sequencer that walks the list memory one entry per cycle for insert, delete and find.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ACT_W-1:0]             in_action,
  input  logic [POS_W-1:0]             in_position,
  input  logic signed [VAL_W-1:0]      in_value,
  input  logic [CMP_W-1:0]             eff_cap,
  output ram_req_t                     ram_req,
  input  logic [DATA_WIDTH-1:0]        ram_rdata,
  output logic                         out_strobe,
  output logic [STAT_W-1:0]            out_status,
  output logic signed [VAL_W-1:0]      out_read_value,
  output logic [IDX_W-1:0]             out_found_index,
  output logic [CNT_W-1:0]             out_count
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_INS_PUT   = 7'b0000100,
    S_DEL_CAP   = 7'b0001000,
    S_DEL_SHIFT = 7'b0010000,
    S_FIND      = 7'b0100000,
    S_GET_CAP   = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      cur_r, cur_nxt;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [CMP_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;
  logic                  strobe_r, strobe_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [VAL_W-1:0]      rdval_r, rdval_nxt;
  logic [IDX_W-1:0]      found_r, found_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CMP_W-1:0]      in_pos_ext;
  logic [CMP_W-1:0]      len_ext;
  logic [CMP_W-1:0]      cur_ext;

  assign in_pos_ext = CMP_W'(in_position);
  assign len_ext    = CMP_W'(len_r);
  assign cur_ext    = CMP_W'(cur_r);
  assign busy       = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    rd_nxt        = rd_r;
    strobe_nxt    = 1'b0;
    status_nxt    = ST_OK;
    rdval_nxt     = '0;
    found_nxt     = '0;
    ram_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt  = in_pos_ext;
          val_nxt  = DATA_WIDTH'($unsigned(in_value));
          pend_nxt = 1'b0;
          unique case (in_action)
            ACT_INSERT: begin
              if (len_ext >= eff_cap) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
              end else if (in_pos_ext > len_ext) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_RANGE;
              end else begin
                cur_nxt   = len_r;
                state_nxt = S_INS_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (in_pos_ext >= len_ext) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ADDR_W'(in_position);
                state_nxt     = S_DEL_CAP;
              end
            end
            ACT_FIND: begin
              cur_nxt   = '0;
              state_nxt = S_FIND;
            end
            ACT_GET: begin
              if (in_pos_ext >= len_ext) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_RANGE;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ADDR_W'(in_position);
                state_nxt     = S_GET_CAP;
              end
            end
            ACT_CLEAR: begin
              len_nxt    = '0;
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        ram_req.we    = pend_r;
        ram_req.waddr = pend_addr_r;
        ram_req.wdata = ram_rdata;
        if (cur_ext > pos_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(cur_r - LEN_W'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = ADDR_W'(cur_r);
          cur_nxt       = cur_r - LEN_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ADDR_W'(pos_r);
        ram_req.wdata = val_r;
        len_nxt       = len_r + LEN_W'(1);
        strobe_nxt    = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DEL_CAP: begin
        rd_nxt    = ram_rdata;
        cur_nxt   = LEN_W'(pos_r + CMP_W'(1));
        pend_nxt  = 1'b0;
        state_nxt = S_DEL_SHIFT;
      end
      S_DEL_SHIFT: begin
        ram_req.we    = pend_r;
        ram_req.waddr = pend_addr_r;
        ram_req.wdata = ram_rdata;
        if (cur_r < len_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(cur_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = ADDR_W'(cur_r - LEN_W'(1));
          cur_nxt       = cur_r + LEN_W'(1);
        end else begin
          pend_nxt   = 1'b0;
          len_nxt    = len_r - LEN_W'(1);
          strobe_nxt = 1'b1;
          rdval_nxt  = VAL_W'(rd_r);
          state_nxt  = S_IDLE;
        end
      end
      S_FIND: begin
        if (pend_r && (ram_rdata == val_r)) begin
          pend_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          found_nxt  = IDX_W'(pend_addr_r);
          state_nxt  = S_IDLE;
        end else if (cur_r < len_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ADDR_W'(cur_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = ADDR_W'(cur_r);
          cur_nxt       = cur_r + LEN_W'(1);
        end else begin
          pend_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end
      end
      S_GET_CAP: begin
        strobe_nxt = 1'b1;
        rdval_nxt  = VAL_W'(ram_rdata);
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    pend_addr_r <= pend_addr_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    rd_r        <= rd_nxt;
    if (strobe_nxt) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
      found_r  <= found_nxt;
      count_r  <= CNT_W'(len_nxt);
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_read_value  = rdval_r;
  assign out_found_index = found_r;
  assign out_count       = count_r;

endmodule

>>> tb/tb_sequential_list_engine.sv
// Self-checking testbench for the sequential list engine with a cycle-free list predictor.
`timescale 1ns / 100ps

module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [ACT_W-1:0]        in_action;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    cfg_we;
  logic [CAP_W-1:0]        cfg_data;
  logic                    out_strobe;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [IDX_W-1:0]        out_found_index;
  logic [CNT_W-1:0]        out_count;

  logic [VAL_W-1:0] list_image [DEPTH];
  int unsigned      list_len;
  logic [CAP_W-1:0] cap_reg;
  reply_t           pending_replies [$];

  bit          burst_mode;
  int          mismatches;
  int          replies_checked;
  int          requests_sent;
  int          cap_writes;
  int          drain_pauses;
  int unsigned longest_list;
  int          act_hits [8];
  int          status_hits [4];
  int          stall_cycles;

  sequential_list_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_found_index(out_found_index),
    .out_count      (out_count)
  );

  always #5 clk = ~clk;

  task automatic apply_list_action(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val);
    reply_t      r;
    int unsigned eff_cap;
    int          i;
    r = '0;
    eff_cap = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    case (act)
      ACT_INSERT: begin
        if (list_len >= eff_cap) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_image[i] = list_image[i-1];
          list_image[pos] = val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_image[pos];
          for (i = pos; i + 1 < list_len; i++) list_image[i] = list_image[i+1];
          list_len--;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_image[i] == val) begin
            r.status = ST_OK;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      ACT_GET: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_value = list_image[pos];
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    if (list_len > longest_list) longest_list = list_len;
    act_hits[act]++;
    status_hits[r.status]++;
    pending_replies.push_back(r);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_action = act;
    in_position = pos;
    in_value = val;
    do @(posedge clk); while (busy);
    apply_list_action(act, pos, val);
    requests_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drain_pauses++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_for_replies();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = cap;
    @(negedge clk);
    cfg_we = 1'b0;
    cap_reg = cap;
    cap_writes++;
  endtask

  task automatic test_directed_basics();
    send_request(ACT_GET, 0, 0);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_FIND, 0, 0);
    send_request(ACT_INSERT, 1, 5);
    send_request(ACT_INSERT, 0, 32'h8000_0000);
    send_request(ACT_INSERT, 1, 32'h7fff_ffff);
    send_request(ACT_INSERT, 0, 32'hffff_ffff);
    send_request(ACT_INSERT, POS_MAX, 0);
    send_request(ACT_INSERT, 3, 0);
    send_request(ACT_GET, 0, 0);
    send_request(ACT_GET, 3, 0);
    send_request(ACT_GET, 4, 0);
    send_request(ACT_GET, 256, 0);
    send_request(ACT_FIND, POS_MAX, 32'h7fff_ffff);
    send_request(ACT_FIND, 0, 0);
    send_request(ACT_FIND, 0, 12345);
    send_request(ACT_INSERT, 2, 32'h7fff_ffff);
    send_request(ACT_FIND, 0, 32'h7fff_ffff);
    send_request(ACT_DELETE, 1, 0);
    send_request(ACT_DELETE, 4, 0);
    send_request(ACT_DELETE, 3, 0);
    send_request(ACT_RSVD5, POS_MAX, $urandom);
    send_request(ACT_RSVD6, 0, $urandom);
    send_request(ACT_RSVD7, POS_MAX, $urandom);
    send_request(ACT_CLEAR, POS_MAX, $urandom);
    send_request(ACT_GET, 0, 0);
  endtask

  task automatic test_capacity_limits();
    int k;
    write_capacity(1);
    send_request(ACT_INSERT, 0, 11);
    send_request(ACT_INSERT, 0, 12);
    send_request(ACT_INSERT, 5, 13);
    send_request(ACT_DELETE, 0, 0);
    write_capacity(0);
    send_request(ACT_INSERT, 0, 14);
    write_capacity(4);
    for (k = 0; k < 4; k++) send_request(ACT_INSERT, 0, 20 + k);
    write_capacity(2);
    send_request(ACT_INSERT, 0, 30);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_INSERT, 1, 31);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_INSERT, 1, 32);
    send_request(ACT_CLEAR, 0, 0);
  endtask

  task automatic test_fill_to_capacity();
    logic [VAL_W-1:0] probe;
    bit               hit;
    int               i;
    write_capacity(POS_MAX);
    send_request(ACT_CLEAR, 0, 0);
    while (list_len < DEPTH)
      send_request(ACT_INSERT, POS_W'($urandom_range(list_len)), pick_value());
    send_request(ACT_INSERT, 0, 1);
    send_request(ACT_INSERT, DEPTH, 1);
    send_request(ACT_GET, DEPTH - 1, 0);
    send_request(ACT_GET, DEPTH, 0);
    send_request(ACT_FIND, 0, list_image[DEPTH-1]);
    probe = $urandom;
    do begin
      hit = 1'b0;
      for (i = 0; i < list_len; i++) if (list_image[i] == probe) hit = 1'b1;
      if (hit) probe = $urandom;
    end while (hit);
    send_request(ACT_FIND, 0, probe);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_INSERT, DEPTH - 1, probe);
    send_request(ACT_FIND, 0, probe);
    send_request(ACT_DELETE, DEPTH - 1, 0);
  endtask

  task automatic run_random_items(input int n_items, input int grow_pct);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               roll;
    int               k;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(63) == 0) burst_mode = !burst_mode;
      if ($urandom_range(149) == 0) wait_for_replies();
      roll = $urandom_range(99);
      if (roll < grow_pct) begin
        act = ACT_INSERT;
      end else begin
        roll = $urandom_range(99);
        if (roll < 40) act = ACT_DELETE;
        else if (roll < 70) act = ACT_FIND;
        else if (roll < 95) act = ACT_GET;
        else if (roll < 98) act = ACT_CLEAR;
        else act = ACT_W'($urandom_range(ACT_RSVD7, ACT_RSVD5));
      end
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(POS_MAX));
      else if (act == ACT_INSERT) pos = POS_W'($urandom_range(list_len));
      else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1));
      else pos = 0;
      val = pick_value();
      if (act == ACT_FIND && list_len > 0 && $urandom_range(9) < 7)
        val = list_image[$urandom_range(list_len - 1)];
      send_request(act, pos, val);
    end
  endtask

  task automatic test_random_mix();
    logic [CAP_W-1:0] caps [8];
    int               p;
    caps = '{9'd16, 9'd1, 9'd0, 9'd300, 9'd5, 9'd64, 9'd256, 9'd0};
    caps[7] = CAP_W'($urandom_range(40, 2));
    for (p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      run_random_items(200, (caps[p] > 64) ? 50 : 60);
    end
  endtask

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected transaction: status %0d read_value %h found_index %0d count %0d",
                 $time, out_status, out_read_value, out_found_index, out_count);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (out_status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, out_status);
          mismatches++;
        end
        if (out_read_value !== want.read_value) begin
          $display("%0t read_value mismatch: expected %h actual %h",
                   $time, want.read_value, out_read_value);
          mismatches++;
        end
        if (out_found_index !== want.found_index) begin
          $display("%0t found_index mismatch: expected %0d actual %0d",
                   $time, want.found_index, out_found_index);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $display("%0t count mismatch: expected %0d actual %0d",
                   $time, want.count, out_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_INSERT;
    in_position = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    list_len = 0;
    cap_reg = CAP_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_basics();
    test_capacity_limits();
    test_fill_to_capacity();
    test_random_mix();

    wait_for_replies();
    repeat (16) @(posedge clk);
    $display("%0d requests: %0d insert, %0d delete, %0d find, %0d get, %0d clear, %0d other",
             requests_sent, act_hits[ACT_INSERT], act_hits[ACT_DELETE], act_hits[ACT_FIND],
             act_hits[ACT_GET], act_hits[ACT_CLEAR], requests_sent - act_hits[ACT_INSERT]
             - act_hits[ACT_DELETE] - act_hits[ACT_FIND] - act_hits[ACT_GET]
             - act_hits[ACT_CLEAR]);
    $display("%0d checked; %0d full, %0d range, %0d missed; %0d cfg writes, %0d drains, peak %0d",
             replies_checked, status_hits[ST_FULL], status_hits[ST_RANGE],
             status_hits[ST_NOT_FOUND], cap_writes, drain_pauses, longest_list);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
